// ----- design/mf3_pkg.sv -----
// Shared types, widths, register codes and defaults for the 3x3 median stream filter.
// No dependencies; every other design file imports this package.
`default_nettype none

package mf3_pkg;

    localparam int DEF_MAX_WIDTH    = 2048;
    localparam int DEF_MAX_HEIGHT   = 2048;
    localparam int DEF_MAX_CHANNELS = 4;

    localparam int PIX_W     = 8;
    localparam int COL_W     = 11;
    localparam int ROW_W     = 11;
    localparam int CHAN_W    = 2;
    localparam int CHAN_SLOTS = 4;
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 2;
    localparam int CMP_W     = 14;
    localparam int NSLOT     = 4;
    localparam int FIFO_DEPTH = 16;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNELS = 2'd2;

    localparam logic [CFG_W-1:0] RST_WIDTH    = 12'd640;
    localparam logic [CFG_W-1:0] RST_HEIGHT   = 12'd480;
    localparam logic [2:0]       RST_CHANNELS = 3'd1;

    typedef logic [PIX_W-1:0] pix_t;
    typedef pix_t [2:0] col_t;
    typedef pix_t [8:0] win_t;

    typedef struct packed {
        pix_t              median;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic [CHAN_W-1:0] chan;
        logic              run_end;
        logic              frame_end;
    } res_t;

endpackage

`default_nettype wire

// ----- design/mf3_median9.sv -----
// Median of nine samples through the fixed 19-step compare-exchange network.
// Depends on mf3_pkg.
`default_nettype none

module mf3_median9
    import mf3_pkg::*;
(
    input  win_t win,
    output pix_t med
);

    function automatic win_t cx(input win_t v, input int i, input int j);
        win_t r;
        r = v;
        if (v[i] > v[j])
        begin
            r[i] = v[j];
            r[j] = v[i];
        end
        return r;
    endfunction

    win_t v;

    always_comb
    begin
        v = win;
        v = cx(v, 1, 2); v = cx(v, 4, 5); v = cx(v, 7, 8);
        v = cx(v, 0, 1); v = cx(v, 3, 4); v = cx(v, 6, 7);
        v = cx(v, 1, 2); v = cx(v, 4, 5); v = cx(v, 7, 8);
        v = cx(v, 0, 3); v = cx(v, 5, 8); v = cx(v, 4, 7);
        v = cx(v, 3, 6); v = cx(v, 1, 4); v = cx(v, 2, 5);
        v = cx(v, 4, 7); v = cx(v, 4, 2); v = cx(v, 6, 4);
        v = cx(v, 4, 2);
    end

    assign med = v[4];

endmodule

`default_nettype wire

// ----- design/mf3_linebuf.sv -----
// Two-row line store: one write and one registered read per cycle, with write bypass.
// Depends on mf3_pkg.
`default_nettype none

module mf3_linebuf
    import mf3_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_WIDTH * DEF_MAX_CHANNELS,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [AW-1:0]        wr_addr,
    input  logic [2*PIX_W-1:0]   wr_data,
    input  logic [AW-1:0]        rd_addr,
    output logic [2*PIX_W-1:0]   rd_data
);

    logic [2*PIX_W-1:0] mem [DEPTH];
    logic [2*PIX_W-1:0] rd_reg;
    logic [2*PIX_W-1:0] byp_data_reg;
    logic               byp_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_reg       <= mem[rd_addr];
        byp_data_reg <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_reg <= 1'b0;
        end
        else
        begin
            byp_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    assign rd_data = byp_reg ? byp_data_reg : rd_reg;

endmodule

`default_nettype wire

// ----- design/mf3_outfifo.sv -----
// Result queue: takes up to four results a cycle in slot order, hands out one.
// Depends on mf3_pkg.
`default_nettype none

module mf3_outfifo
    import mf3_pkg::*;
#(
    parameter int DEPTH = FIFO_DEPTH,
    parameter int PW    = $clog2(DEPTH)
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [NSLOT-1:0]     push_vld,
    input  res_t [NSLOT-1:0]     push_data,
    input  logic                 pop,
    output res_t                 head,
    output logic                 not_empty,
    output logic [PW:0]          count
);

    res_t            ent_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [PW:0]     cnt_reg, cnt_next;
    logic [PW-1:0]   off [NSLOT];
    logic [PW:0]     n_push;

    always_comb
    begin
        off[0] = '0;
        for (int s = 1; s < NSLOT; s++)
        begin
            off[s] = off[s-1] + PW'(push_vld[s-1]);
        end
        n_push = '0;
        for (int s = 0; s < NSLOT; s++)
        begin
            n_push = n_push + (PW+1)'(push_vld[s]);
        end
        wr_ptr_next = wr_ptr_reg + PW'(n_push);
        rd_ptr_next = rd_ptr_reg + PW'(pop);
        cnt_next    = cnt_reg + n_push - (PW+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < NSLOT; s++)
        begin
            if (push_vld[s])
            begin
                ent_reg[wr_ptr_reg + off[s]] <= push_data[s];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    assign head      = ent_reg[rd_ptr_reg];
    assign not_empty = (cnt_reg != '0);
    assign count     = cnt_reg;

endmodule

`default_nettype wire

// ----- design/median_filter_3x3_stream.sv -----
// Streaming 3x3 median filter with replicated edges, channels interleaved.
// Depends on mf3_pkg, mf3_linebuf, mf3_median9 and mf3_outfifo.
//
// Usage: samples enter on in_valid/in_ready in raster order, channel fastest.
// Results leave on out_valid/out_ready with median, coordinates, channel,
// run_end (last result of one input request) and frame_end (last of frame).
// Registers image_width, image_height, channel_count are written on
// cfg_valid/cfg_ready (always ready); the user must write them only between
// frames or while idle, which the block does not enforce. A request's results
// are registered in the window stage and pass the median network into the
// queue. Throughput: one sample per cycle while in_ready is high; each sample
// makes zero to four results, which go into a 16-entry queue drained one per
// cycle while out_ready is high. The input takes a request only while the
// queue, plus the results still in the window stage, leaves room for four
// more; on the last row (two results per sample) the queue drain limits the
// input rate. When the receiver stalls the queue fills and in_ready drops;
// nothing is lost. Reset clears position, queue and registers to their defaults;
// the line store is not cleared; no result reads an entry before it is written.
`default_nettype none

module median_filter_3x3_stream
    import mf3_pkg::*;
#(
    parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT   = DEF_MAX_HEIGHT,
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [PIX_W-1:0]     sample,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [PIX_W-1:0]     median,
    output logic [COL_W-1:0]     out_col,
    output logic [ROW_W-1:0]     out_row,
    output logic [CHAN_W-1:0]    out_chan,
    output logic                 run_end,
    output logic                 frame_end,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int DEPTH = MAX_WIDTH * MAX_CHANNELS;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = $clog2(FIFO_DEPTH);

    logic [CFG_W-1:0]  width_reg;
    logic [CFG_W-1:0]  height_reg;
    logic [2:0]        chans_reg;

    logic [XW-1:0]     col_pos_reg, col_pos_next;
    logic [YW-1:0]     row_pos_reg, row_pos_next;
    logic [CHAN_W-1:0] chan_pos_reg, chan_pos_next;

    col_t              rc0_reg [CHAN_SLOTS];
    col_t              rc1_reg [CHAN_SLOTS];

    win_t              win_reg [NSLOT];
    res_t [NSLOT-1:0]  meta_reg;
    logic [NSLOT-1:0]  vld_reg;

    logic [CMP_W-1:0]  w_eff, h_eff, ch_eff;
    logic              last_col, last_row, last_chan;
    logic              acc;
    logic [AW-1:0]     idx, nidx, rd_addr;
    logic [2*PIX_W-1:0] line_rd;
    col_t              cur, rc0c, rc1c, xm1_c0, x_c0;
    logic              yge1, yge2, xge1, xge2;
    win_t              win_next [NSLOT];
    res_t [NSLOT-1:0]  meta_next;
    logic [NSLOT-1:0]  vld_next;
    pix_t              med [NSLOT];
    res_t [NSLOT-1:0]  push_data;
    res_t              head;
    logic [PW:0]       fifo_cnt;
    logic [PW:0]       pend_n;

    function automatic win_t form(input col_t t0, input col_t t1, input col_t t2,
                                  input logic upper, input logic y1, input logic y2);
        win_t v;
        col_t t [3];
        t[0] = t0;
        t[1] = t1;
        t[2] = t2;
        for (int k = 0; k < 3; k++)
        begin
            if (upper)
            begin
                v[k]     = y2 ? t[k][0] : t[k][1];
                v[3 + k] = t[k][1];
                v[6 + k] = t[k][2];
            end
            else
            begin
                v[k]     = y1 ? t[k][1] : t[k][2];
                v[3 + k] = t[k][2];
                v[6 + k] = t[k][2];
            end
        end
        return v;
    endfunction

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RST_WIDTH;
            height_reg <= RST_HEIGHT;
            chans_reg  <= RST_CHANNELS;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_WIDTH:    width_reg  <= cfg_data;
                REG_HEIGHT:   height_reg <= cfg_data;
                REG_CHANNELS: chans_reg  <= cfg_data[2:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        w_eff  = (width_reg == '0) ? CMP_W'(1) :
                 (CMP_W'(width_reg) > CMP_W'(MAX_WIDTH)) ? CMP_W'(MAX_WIDTH) :
                 CMP_W'(width_reg);
        h_eff  = (height_reg == '0) ? CMP_W'(1) :
                 (CMP_W'(height_reg) > CMP_W'(MAX_HEIGHT)) ? CMP_W'(MAX_HEIGHT) :
                 CMP_W'(height_reg);
        ch_eff = (chans_reg == '0) ? CMP_W'(1) :
                 (CMP_W'(chans_reg) > CMP_W'(MAX_CHANNELS)) ? CMP_W'(MAX_CHANNELS) :
                 CMP_W'(chans_reg);
        last_col  = (CMP_W'(col_pos_reg) + CMP_W'(1)) >= w_eff;
        last_row  = (CMP_W'(row_pos_reg) + CMP_W'(1)) >= h_eff;
        last_chan = (CMP_W'(chan_pos_reg) + CMP_W'(1)) >= ch_eff;

        col_pos_next  = col_pos_reg;
        row_pos_next  = row_pos_reg;
        chan_pos_next = chan_pos_reg + CHAN_W'(1);
        if (last_chan)
        begin
            chan_pos_next = '0;
            if (!last_col)
            begin
                col_pos_next = col_pos_reg + XW'(1);
            end
            else
            begin
                col_pos_next = '0;
                row_pos_next = last_row ? '0 : row_pos_reg + YW'(1);
            end
        end

        idx     = AW'(col_pos_reg) * AW'(MAX_CHANNELS) + AW'(chan_pos_reg);
        nidx    = AW'(col_pos_next) * AW'(MAX_CHANNELS) + AW'(chan_pos_next);
        rd_addr = acc ? nidx : idx;
    end

    assign pend_n = (PW+1)'(vld_reg[0]) + (PW+1)'(vld_reg[1])
                  + (PW+1)'(vld_reg[2]) + (PW+1)'(vld_reg[3]);
    assign in_ready = (fifo_cnt + pend_n) <= (PW+1)'(FIFO_DEPTH - NSLOT);
    assign acc      = in_valid && in_ready;

    mf3_linebuf #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_linebuf (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (acc),
        .wr_addr (idx),
        .wr_data ({line_rd[PIX_W-1:0], sample}),
        .rd_addr (rd_addr),
        .rd_data (line_rd)
    );

    always_comb
    begin
        cur[0] = line_rd[2*PIX_W-1:PIX_W];
        cur[1] = line_rd[PIX_W-1:0];
        cur[2] = sample;
        rc0c   = rc0_reg[chan_pos_reg];
        rc1c   = rc1_reg[chan_pos_reg];
        yge1   = (row_pos_reg != '0);
        yge2   = (CMP_W'(row_pos_reg) >= CMP_W'(2));
        xge1   = (col_pos_reg != '0);
        xge2   = (CMP_W'(col_pos_reg) >= CMP_W'(2));
        xm1_c0 = xge2 ? rc1c : rc0c;
        x_c0   = xge1 ? rc0c : cur;

        win_next[0] = form(xm1_c0, rc0c, cur, 1'b1, yge1, yge2);
        win_next[1] = form(x_c0, cur, cur, 1'b1, yge1, yge2);
        win_next[2] = form(xm1_c0, rc0c, cur, 1'b0, yge1, yge2);
        win_next[3] = form(x_c0, cur, cur, 1'b0, yge1, yge2);

        vld_next[0] = yge1 && xge1;
        vld_next[1] = yge1 && last_col;
        vld_next[2] = last_row && xge1;
        vld_next[3] = last_row && last_col;

        for (int s = 0; s < NSLOT; s++)
        begin
            meta_next[s].median    = '0;
            meta_next[s].col       = (s == 0 || s == 2) ?
                                     COL_W'(col_pos_reg - XW'(1)) : COL_W'(col_pos_reg);
            meta_next[s].row       = (s < 2) ?
                                     ROW_W'(row_pos_reg - YW'(1)) : ROW_W'(row_pos_reg);
            meta_next[s].chan      = chan_pos_reg;
            meta_next[s].frame_end = (s == 3) && last_chan;
        end
        meta_next[3].run_end = vld_next[3];
        meta_next[2].run_end = vld_next[2] && !vld_next[3];
        meta_next[1].run_end = vld_next[1] && !vld_next[2] && !vld_next[3];
        meta_next[0].run_end = vld_next[0] && !vld_next[1] && !vld_next[2] && !vld_next[3];
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            rc1_reg[chan_pos_reg] <= rc0c;
            rc0_reg[chan_pos_reg] <= cur;
            for (int s = 0; s < NSLOT; s++)
            begin
                win_reg[s] <= win_next[s];
            end
            meta_reg <= meta_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_pos_reg  <= '0;
            row_pos_reg  <= '0;
            chan_pos_reg <= '0;
            vld_reg      <= '0;
        end
        else
        begin
            vld_reg <= acc ? vld_next : '0;
            if (acc)
            begin
                col_pos_reg  <= col_pos_next;
                row_pos_reg  <= row_pos_next;
                chan_pos_reg <= chan_pos_next;
            end
        end
    end

    for (genvar g = 0; g < NSLOT; g++)
    begin : g_med
        mf3_median9 u_med (
            .win (win_reg[g]),
            .med (med[g])
        );
    end

    always_comb
    begin
        for (int s = 0; s < NSLOT; s++)
        begin
            push_data[s]        = meta_reg[s];
            push_data[s].median = med[s];
        end
    end

    mf3_outfifo #(
        .DEPTH (FIFO_DEPTH),
        .PW    (PW)
    ) u_outfifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_vld  (vld_reg),
        .push_data (push_data),
        .pop       (out_valid && out_ready),
        .head      (head),
        .not_empty (out_valid),
        .count     (fifo_cnt)
    );

    assign median    = head.median;
    assign out_col   = head.col;
    assign out_row   = head.row;
    assign out_chan  = head.chan;
    assign run_end   = head.run_end;
    assign frame_end = head.frame_end;

    a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_cnt <= (PW+1)'(FIFO_DEPTH))
        else $error("result queue overflow");

    a_pend_from_req: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg != '0) |-> $past(in_valid && in_ready))
        else $error("window stage loaded without a request");

    a_room: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (fifo_cnt + pend_n + (PW+1)'(NSLOT)) <= (PW+1)'(FIFO_DEPTH))
        else $error("request taken without queue room");

    a_fend_run: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[3] && meta_reg[3].frame_end) |-> meta_reg[3].run_end)
        else $error("frame end not on last result of request");

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking testbench for median_filter_3x3_stream: directed table, then random frames.
// Depends on mf3_pkg and the median_filter_3x3_stream RTL; predicts most results in place.
`default_nettype none

module testbench
    import mf3_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int LINE_DEPTH    = DEF_MAX_WIDTH * DEF_MAX_CHANNELS;
    localparam int STALL_LIMIT   = 4000;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_ITEMS  = 110;

    typedef struct {
        bit                   is_cfg;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_W-1:0]     data;
        pix_t                 smp;
        bit                   lit;
        res_t                 want;
    } stim_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [PIX_W-1:0]     sample;
    logic                 out_valid;
    logic                 out_ready;
    logic [PIX_W-1:0]     median;
    logic [COL_W-1:0]     out_col;
    logic [ROW_W-1:0]     out_row;
    logic [CHAN_W-1:0]    out_chan;
    logic                 run_end;
    logic                 frame_end;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    median_filter_3x3_stream u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .sample    (sample),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .median    (median),
        .out_col   (out_col),
        .out_row   (out_row),
        .out_chan  (out_chan),
        .run_end   (run_end),
        .frame_end (frame_end),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    logic [CFG_W-1:0] shadow_width;
    logic [CFG_W-1:0] shadow_height;
    logic [2:0]       shadow_chans;
    pix_t             line_prev  [LINE_DEPTH];
    pix_t             line_prev2 [LINE_DEPTH];
    pix_t             col_prev   [CHAN_SLOTS][3];
    pix_t             col_prev2  [CHAN_SLOTS][3];
    int               pos_col;
    int               pos_row;
    int               pos_chan;

    res_t             pending_medians[$];
    stim_row_t        stim_rows[$];
    int               errors;
    int               idle_cycles;
    int               burst_left;
    int               random_items;
    bit               hold_req;
    bit               hold_done;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int clamp_cfg(int v, int hi);
        if (v < 1)
            return 1;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic pix_t median_of9(pix_t v[9]);
        int   pairs[19][2];
        pix_t t;
        pairs = '{'{1, 2}, '{4, 5}, '{7, 8}, '{0, 1}, '{3, 4}, '{6, 7}, '{1, 2},
                  '{4, 5}, '{7, 8}, '{0, 3}, '{5, 8}, '{4, 7}, '{3, 6}, '{1, 4},
                  '{2, 5}, '{4, 7}, '{4, 2}, '{6, 4}, '{4, 2}};
        for (int i = 0; i < 19; i++)
        begin
            if (v[pairs[i][0]] > v[pairs[i][1]])
            begin
                t = v[pairs[i][0]];
                v[pairs[i][0]] = v[pairs[i][1]];
                v[pairs[i][1]] = t;
            end
        end
        return v[4];
    endfunction

    function automatic res_t window_median(int ox, bit upper, int x, int y, int c,
                                           pix_t cur[3], bit fend);
        pix_t v[9];
        pix_t t[3];
        int   j;
        res_t r;
        for (int k = 0; k < 3; k++)
        begin
            j = ox - 1 + k;
            if (j < 0)
                j = 0;
            if (j > x)
                j = x;
            if (j == x)
                t = cur;
            else if (j == x - 1)
                t = col_prev[c];
            else
                t = col_prev2[c];
            if (upper)
            begin
                v[k]     = (y >= 2) ? t[0] : t[1];
                v[3 + k] = t[1];
                v[6 + k] = t[2];
            end
            else
            begin
                v[k]     = (y >= 1) ? t[1] : t[2];
                v[3 + k] = t[2];
                v[6 + k] = t[2];
            end
        end
        r.median    = median_of9(v);
        r.col       = COL_W'(ox);
        r.row       = ROW_W'(upper ? y - 1 : y);
        r.chan      = CHAN_W'(c);
        r.run_end   = 1'b0;
        r.frame_end = fend;
        return r;
    endfunction

    task automatic predict_medians(input pix_t s, output res_t outs[$]);
        int   w;
        int   h;
        int   nch;
        int   x;
        int   y;
        int   c;
        int   idx;
        bit   last_col;
        bit   last_row;
        bit   last_chan;
        pix_t cur[3];
        w   = clamp_cfg(shadow_width, DEF_MAX_WIDTH);
        h   = clamp_cfg(shadow_height, DEF_MAX_HEIGHT);
        nch = clamp_cfg(shadow_chans, DEF_MAX_CHANNELS);
        x = pos_col;
        y = pos_row;
        c = pos_chan;
        last_col  = (x + 1 >= w);
        last_row  = (y + 1 >= h);
        last_chan = (c + 1 >= nch);
        idx = (x * DEF_MAX_CHANNELS + c) % LINE_DEPTH;
        cur[0] = line_prev2[idx];
        cur[1] = line_prev[idx];
        cur[2] = s;
        outs = {};
        if (y >= 1)
        begin
            if (x >= 1)
                outs.push_back(window_median(x - 1, 1'b1, x, y, c, cur, 1'b0));
            if (last_col)
                outs.push_back(window_median(x, 1'b1, x, y, c, cur, 1'b0));
        end
        if (last_row)
        begin
            if (x >= 1)
                outs.push_back(window_median(x - 1, 1'b0, x, y, c, cur, 1'b0));
            if (last_col)
                outs.push_back(window_median(x, 1'b0, x, y, c, cur, last_chan));
        end
        if (outs.size() > 0)
            outs[outs.size() - 1].run_end = 1'b1;
        line_prev2[idx] = cur[1];
        line_prev[idx]  = cur[2];
        col_prev2[c] = col_prev[c];
        col_prev[c]  = cur;
        if (!last_chan)
            pos_chan = c + 1;
        else
        begin
            pos_chan = 0;
            if (!last_col)
                pos_col = x + 1;
            else
            begin
                pos_col = 0;
                pos_row = last_row ? 0 : y + 1;
            end
        end
    endtask

    task automatic wait_drained();
        while (pending_medians.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        wait_drained();
        repeat (10) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_WIDTH:    shadow_width  = data;
            REG_HEIGHT:   shadow_height = data;
            REG_CHANNELS: shadow_chans  = data[2:0];
            default:      ;
        endcase
    endtask

    task automatic send_sample(input pix_t s, output res_t outs[$]);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        in_valid <= 1'b1;
        sample   <= s;
        do
            @(posedge clk);
        while (!in_ready);
        predict_medians(s, outs);
    endtask

    task automatic stream_frame(input int w, input int h, input int nch, input bit pause_mid);
        res_t outs[$];
        int   total;
        pix_t s;
        write_reg(REG_WIDTH, CFG_W'(w));
        write_reg(REG_HEIGHT, CFG_W'(h));
        write_reg(REG_CHANNELS, CFG_W'(nch));
        total = clamp_cfg(w, DEF_MAX_WIDTH) * clamp_cfg(h, DEF_MAX_HEIGHT)
              * clamp_cfg(nch & 7, DEF_MAX_CHANNELS);
        for (int i = 0; i < total; i++)
        begin
            case ($urandom_range(0, 9))
                0:       s = 8'h00;
                1:       s = 8'hFF;
                default: s = PIX_W'($urandom_range(0, 255));
            endcase
            send_sample(s, outs);
            foreach (outs[k])
                pending_medians.push_back(outs[k]);
            if (pause_mid && i == total / 2)
            begin
                in_valid <= 1'b0;
                burst_left = 0;
                wait_drained();
            end
        end
        in_valid <= 1'b0;
        burst_left = 0;
        random_items += total;
    endtask

    function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        stim_row_t r;
        r = '{default: '0};
        r.is_cfg = 1'b1;
        r.idx    = idx;
        r.data   = data;
        stim_rows.push_back(r);
    endfunction

    function automatic void add_smp(pix_t s, bit lit);
        stim_row_t r;
        r = '{default: '0};
        r.smp  = s;
        r.lit  = lit;
        r.want = '{median: s, col: '0, row: '0, chan: '0, run_end: 1'b1, frame_end: 1'b1};
        stim_rows.push_back(r);
    endfunction

    task automatic check_median(input res_t e);
        if (median !== e.median)
        begin
            $error("median: expected %0d, got %0d", e.median, median);
            errors++;
        end
        if (out_col !== e.col)
        begin
            $error("out_col: expected %0d, got %0d", e.col, out_col);
            errors++;
        end
        if (out_row !== e.row)
        begin
            $error("out_row: expected %0d, got %0d", e.row, out_row);
            errors++;
        end
        if (out_chan !== e.chan)
        begin
            $error("out_chan: expected %0d, got %0d", e.chan, out_chan);
            errors++;
        end
        if (run_end !== e.run_end)
        begin
            $error("run_end: expected %0d, got %0d", e.run_end, run_end);
            errors++;
        end
        if (frame_end !== e.frame_end)
        begin
            $error("frame_end: expected %0d, got %0d", e.frame_end, frame_end);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_medians.size() == 0)
            begin
                $error("unexpected result at col %0d row %0d chan %0d",
                       out_col, out_row, out_chan);
                errors++;
            end
            else
                check_median(pending_medians.pop_front());
        end
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        int stall_pct;
        int mode_cnt;
        out_ready = 1'b0;
        mode_cnt  = 0;
        stall_pct = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            else
            begin
                if (mode_cnt == 0)
                begin
                    case ($urandom_range(0, 2))
                        0:       stall_pct = 0;
                        1:       stall_pct = 30;
                        default: stall_pct = 70;
                    endcase
                    mode_cnt = 64;
                end
                mode_cnt--;
                out_ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    initial
    begin
        res_t outs[$];
        int   w;
        int   h;
        int   nch;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        sample    = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_WIDTH;
        cfg_data  = '0;
        errors       = 0;
        idle_cycles  = 0;
        burst_left   = 0;
        random_items = 0;
        hold_req     = 1'b0;
        hold_done    = 1'b0;
        shadow_width  = RST_WIDTH;
        shadow_height = RST_HEIGHT;
        shadow_chans  = RST_CHANNELS;
        pos_col  = 0;
        pos_row  = 0;
        pos_chan = 0;
        foreach (line_prev[i])
        begin
            line_prev[i]  = '0;
            line_prev2[i] = '0;
        end
        foreach (col_prev[c, k])
        begin
            col_prev[c][k]  = '0;
            col_prev2[c][k] = '0;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        add_cfg(REG_WIDTH, 12'd1);
        add_cfg(REG_HEIGHT, 12'd1);
        add_cfg(REG_CHANNELS, 12'd1);
        add_smp(8'h00, 1'b1);
        add_smp(8'hFF, 1'b1);
        add_smp(8'h5A, 1'b1);
        add_smp(8'hA5, 1'b1);
        add_cfg(REG_UNUSED, 12'hFFF);
        add_cfg(REG_WIDTH, 12'd0);
        add_cfg(REG_CHANNELS, 12'd0);
        add_smp(8'h3C, 1'b1);
        add_cfg(REG_WIDTH, 12'd3);
        add_cfg(REG_HEIGHT, 12'd3);
        add_cfg(REG_CHANNELS, 12'd1);
        add_smp(8'h10, 1'b0);
        add_smp(8'hF0, 1'b0);
        add_smp(8'h00, 1'b0);
        add_smp(8'hFF, 1'b0);
        add_smp(8'h80, 1'b0);
        add_smp(8'h7F, 1'b0);
        add_smp(8'h01, 1'b0);
        add_smp(8'hFE, 1'b0);
        add_smp(8'h42, 1'b0);
        add_cfg(REG_WIDTH, 12'd2);
        add_cfg(REG_HEIGHT, 12'd2);
        add_cfg(REG_CHANNELS, 12'd2);
        add_smp(8'h11, 1'b0);
        add_smp(8'hEE, 1'b0);
        add_smp(8'h22, 1'b0);
        add_smp(8'hDD, 1'b0);
        add_smp(8'h33, 1'b0);
        add_smp(8'hCC, 1'b0);
        add_smp(8'h44, 1'b0);
        add_smp(8'hBB, 1'b0);

        foreach (stim_rows[i])
        begin
            if (stim_rows[i].is_cfg)
            begin
                in_valid <= 1'b0;
                burst_left = 0;
                write_reg(stim_rows[i].idx, stim_rows[i].data);
            end
            else
            begin
                send_sample(stim_rows[i].smp, outs);
                if (stim_rows[i].lit)
                    pending_medians.push_back(stim_rows[i].want);
                else
                    foreach (outs[k])
                        pending_medians.push_back(outs[k]);
            end
        end
        in_valid <= 1'b0;
        burst_left = 0;

        stream_frame(2, 2, 7, 1'b0);

        wait_drained();
        hold_req = 1'b1;
        stream_frame(5, 4, 2, 1'b0);
        stream_frame(4, 3, 2, 1'b1);
        while (random_items < RANDOM_ITEMS)
        begin
            w   = $urandom_range(1, 4);
            h   = $urandom_range(1, 3);
            nch = $urandom_range(1, 2);
            stream_frame(w, h, nch, 1'b0);
        end

        wait_drained();
        repeat (20) @(posedge clk);
        if (errors == 0 && pending_medians.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire
